// ===== rtl/indexed_list_store_macros.svh =====
// Assertion macros for the indexed list store.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ILS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ils_pkg.sv =====
// Shared types, codes and helper functions of the indexed list store.
// Used by the cell, the read tree and the top level; no dependencies.
`default_nettype none

package ils_pkg;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Read value returned when nothing was read.
    localparam logic signed [31:0] NO_VALUE = 32'sh8000_0000;

    // Position code that names the tail.
    localparam logic signed [7:0] POS_TAIL = -8'sd1;

    // Shift command broadcast to every cell.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic signed [31:0] value;
    } t_cell_ctl;

    // Number of register levels of the eight-way read tree.
    function automatic int tree_levels(input int cap);
        int lv;
        lv = ($clog2(cap) + 2) / 3;
        return lv;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ils_in_if.sv =====
// Request channel of the indexed list store: valid/ready plus one operation item.
// Depends on nothing but the field widths given by the block.
`default_nettype none

interface ils_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [7:0]  position;
    logic signed [31:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/ils_out_if.sv =====
// Result channel of the indexed list store: valid/ready plus one result item.
// Depends on nothing but the field widths given by the block.
`default_nettype none

interface ils_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         count;

    modport source (output valid, output status, output read_value, output count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ils_cell.sv =====
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
// Depends on ils_pkg for the shift command struct.
`default_nettype none

module ils_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6
) (
    input  wire logic               i_clk,
    input  wire ils_pkg::t_cell_ctl i_ctl,
    input  wire logic [IW-1:0]      i_key,
    input  wire logic [31:0]        i_left,
    input  wire logic [31:0]        i_right,
    output logic [31:0]             o_data,
    output logic [31:0]             o_tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [31:0] r_data;
    logic        w_hit;
    logic        w_above;

    assign w_hit   = (i_key == MY_IDX);
    assign w_above = (MY_IDX > i_key);

    // Insert opens a gap at the key by moving higher entries up one place;
    // delete closes it by pulling the higher entries down. Otherwise the entry holds.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.ins && w_above) begin
            r_data <= i_left;
        end else if (i_ctl.ins && w_hit) begin
            r_data <= i_ctl.value;
        end else if (i_ctl.del && (w_above || w_hit)) begin
            r_data <= i_right;
        end else begin
            r_data <= r_data;
        end
    end

    assign o_data = r_data;
    assign o_tap  = w_hit ? r_data : 32'h0;

endmodule

`default_nettype wire

// ===== rtl/ils_rdtree.sv =====
// Registered eight-way OR tree that gathers the one selected cell tap into a word.
// Depends on ils_pkg for the level count.
`default_nettype none

module ils_rdtree #(
    parameter int CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_leaf [CAPACITY],
    output logic [31:0]      o_root
);

    localparam int LEVELS = ils_pkg::tree_levels(CAPACITY);
    localparam int NLEAF  = 1 << (3 * LEVELS);
    localparam int NINT   = (NLEAF - 1) / 7;

    logic [31:0] w_leaf [NLEAF];
    logic [31:0] r_node [NINT];

    for (genvar x = 0; x < NLEAF; x++) begin : g_leaf
        if (x < CAPACITY) begin : g_real
            assign w_leaf[x] = i_leaf[x];
        end else begin : g_pad
            assign w_leaf[x] = 32'h0;
        end
    end

    // Node j takes children 8j+1 .. 8j+8; indices past the inner nodes are leaves.
    for (genvar j = 0; j < NINT; j++) begin : g_node
        logic [31:0] w_kid [8];
        logic [31:0] w_or;

        for (genvar m = 0; m < 8; m++) begin : g_kid
            if (8 * j + 1 + m < NINT) begin : g_inner
                assign w_kid[m] = r_node[8 * j + 1 + m];
            end else begin : g_outer
                assign w_kid[m] = w_leaf[8 * j + 1 + m - NINT];
            end
        end

        always_comb begin
            w_or = 32'h0;
            for (int m = 0; m < 8; m++) begin
                w_or = w_or | w_kid[m];
            end
        end

        always_ff @(posedge i_clk) begin
            r_node[j] <= w_or;
        end
    end

    assign o_root = r_node[0];

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store.sv =====
// Top level of the indexed list store: control, fill count, cell chain and read tree.
// Depends on ils_pkg, ils_in_if, ils_out_if, ils_cell, ils_rdtree and the macro header.
//
// Usage. Requests arrive on i_in (op, position, value) and every request gives exactly
// one result item on o_out (status, read_value, count), both with valid/ready; an item
// moves at a rising edge where valid and ready are both high. Position -1 names the
// tail. The list lives in a chain of CAPACITY cells; insert and delete shift the cells at
// and above the target by one place at once, and a read gathers the selected cell through
// a registered eight-way OR tree of LEVELS = ceil(log2(CAPACITY) / 3) stages (two at 64 entries).
// One request is in flight at a time: it is accepted in the idle cycle, executed in the
// next cycle, and its result is registered once it has passed the read tree stages; the
// block takes no new request until that result has been loaded into the output register.
// The result sits in an output register, so the next request is accepted while an
// earlier result still waits; if the receiver keeps ready low, the following request
// stops in its final stage until the output register frees up.
// Reset (synchronous, active low) empties the list and drops any pending result; the
// entries themselves are not cleared and need no clearing pass. A clear request only
// sets the count to zero.
`default_nettype none
`include "indexed_list_store_macros.svh"

module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ils_in_if.sink     i_in,
    ils_out_if.source  o_out
);

    localparam int IW     = $clog2(CAPACITY);
    localparam int FW     = $clog2(CAPACITY + 1);
    localparam int CW     = (FW > 7) ? FW : 7;
    localparam int LEVELS = ils_pkg::tree_levels(CAPACITY);
    localparam int NW     = $clog2(LEVELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_WAIT = 3'b100
    } t_state;

    // Control state.
    t_state          r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;

    // Request held for the duration of the operation.
    logic [1:0]         r_op;
    logic signed [7:0]  r_pos;
    logic signed [31:0] r_value;

    // Result bookkeeping.
    logic [1:0]  r_status;
    logic        r_is_read;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_read;
    logic [6:0]  r_out_count;

    // Decode of the held request.
    logic            w_accept;
    logic            w_pos_tail;
    logic            w_pos_below;
    logic [CW-1:0]   w_pos_ext;
    logic [CW-1:0]   w_fill_ext;
    logic [CW-1:0]   w_k;
    logic [IW-1:0]   w_key;
    logic            w_full;
    logic            w_ins_err;
    logic            w_acc_err;
    logic [1:0]      w_status;
    logic            w_slot_free;
    logic            w_load;
    ils_pkg::t_cell_ctl w_ctl;

    // Chain and tree wiring.
    logic [31:0] w_data  [CAPACITY];
    logic [31:0] w_left  [CAPACITY];
    logic [31:0] w_right [CAPACITY];
    logic [31:0] w_tap   [CAPACITY];
    logic [31:0] w_root;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;

    // Position checks: -1 is the tail, other negative codes are out of range.
    assign w_pos_tail  = (r_pos == ils_pkg::POS_TAIL);
    assign w_pos_below = r_pos[7] && !w_pos_tail;
    assign w_pos_ext   = CW'(r_pos[6:0]);
    assign w_fill_ext  = CW'(r_fill);
    assign w_full      = (r_fill == FW'(CAPACITY));

    // Insert may land at the current length; read and delete must name an element.
    assign w_ins_err = w_pos_below || (!r_pos[7] && (w_pos_ext > w_fill_ext));
    assign w_acc_err = (r_fill == '0) || w_pos_below
                       || (!r_pos[7] && (w_pos_ext >= w_fill_ext));

    // Target index. An out-of-range key is never acted upon.
    always_comb begin
        if (!w_pos_tail) begin
            w_k = w_pos_ext;
        end else if (r_op == ils_pkg::OP_INSERT) begin
            w_k = w_fill_ext;
        end else begin
            w_k = w_fill_ext - CW'(1);
        end
    end
    assign w_key = w_k[IW-1:0];

    always_comb begin
        unique case (r_op)
            ils_pkg::OP_INSERT: begin
                if (w_ins_err) begin
                    w_status = ils_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    w_status = ils_pkg::ST_OK;
                end
            end
            ils_pkg::OP_READ, ils_pkg::OP_DELETE: begin
                w_status = w_acc_err ? ils_pkg::ST_RANGE : ils_pkg::ST_OK;
            end
            default: begin
                w_status = ils_pkg::ST_OK;
            end
        endcase
    end

    // The cells shift only in the execute cycle of a successful insert or delete.
    always_comb begin
        w_ctl.ins   = (r_state == ST_EXEC) && (r_op == ils_pkg::OP_INSERT)
                      && (w_status == ils_pkg::ST_OK);
        w_ctl.del   = (r_state == ST_EXEC) && (r_op == ils_pkg::OP_DELETE)
                      && (w_status == ils_pkg::ST_OK);
        w_ctl.value = r_value;
    end

    // The root of the read tree is valid once the count reaches the tree depth.
    assign w_load = (r_state == ST_WAIT) && (r_cnt == NW'(LEVELS)) && w_slot_free;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_cnt   = NW'(1);
                n_state = ST_WAIT;
                if (r_op == ils_pkg::OP_CLEAR) begin
                    n_fill = '0;
                end else if (w_ctl.ins) begin
                    n_fill = r_fill + FW'(1);
                end else if (w_ctl.del) begin
                    n_fill = r_fill - FW'(1);
                end
            end
            ST_WAIT: begin
                if (r_cnt != NW'(LEVELS)) begin
                    n_cnt = r_cnt + NW'(1);
                end else if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_in.op;
            r_pos   <= i_in.position;
            r_value <= i_in.value;
        end
        if (r_state == ST_EXEC) begin
            r_status  <= w_status;
            r_is_read <= (r_op == ils_pkg::OP_READ) && (w_status == ils_pkg::ST_OK);
        end
        if (w_load) begin
            r_out_status <= r_status;
            r_out_read   <= r_is_read ? w_root : ils_pkg::NO_VALUE;
            r_out_count  <= 7'(r_fill);
        end
    end

    // Cell chain: each cell sees its lower and upper neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_left[i] = 32'h0;
        end else begin : g_lnb
            assign w_left[i] = w_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right[i] = w_data[i];
        end else begin : g_rnb
            assign w_right[i] = w_data[i+1];
        end

        ils_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_key   (w_key),
            .i_left  (w_left[i]),
            .i_right (w_right[i]),
            .o_data  (w_data[i]),
            .o_tap   (w_tap[i])
        );
    end

    ils_rdtree #(
        .CAPACITY (CAPACITY)
    ) u_rdtree (
        .i_clk  (i_clk),
        .i_leaf (w_tap),
        .o_root (w_root)
    );

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.read_value = r_out_read;
    assign o_out.count      = r_out_count;

    // The fill count never passes the capacity.
    `ILS_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(CAPACITY), "fill above capacity")

    // An accepted request always goes straight to execution.
    `ILS_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, w_accept, r_state == ST_EXEC, "accept without execute")

    // A successful insert grows the list by exactly one.
    `ILS_ASSERT_NEXT(a_ins_grow, i_clk, i_rst_n, w_ctl.ins, r_fill == $past(r_fill) + FW'(1), "insert did not grow list")

    // A rejected request leaves the list length alone.
    `ILS_ASSERT_NEXT(a_err_hold, i_clk, i_rst_n, (r_state == ST_EXEC) && (w_status != ils_pkg::ST_OK), $stable(r_fill), "rejected request changed fill")

    // A result is only loaded into a free output register.
    `ILS_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_load, !r_out_valid || o_out.ready, "result overwrote pending result")

endmodule

`default_nettype wire
